[design/pcw_pkg.sv]
// Shared constants and types for the point curvature window block.
// Depends on nothing; imported by point_curvature_window_top.
`default_nettype none

package pcw_pkg;

    // Window geometry and coordinate width.
    localparam int HALF_WINDOW = 5;
    localparam int COORD_BITS  = 18;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;

    // Port widths fixed by the item format.
    localparam int POS_W      = 18;
    localparam int CURV_W     = 45;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 45;

    // Datapath widths: the window sum grows by the log2 of the window length, the
    // difference by the log2 of twice the half window plus a sign bit.
    localparam int SUM_W   = COORD_BITS + $clog2(WIN_LEN);
    localparam int DIFF_W  = COORD_BITS + $clog2(2 * HALF_WINDOW) + 1;
    localparam int SQ_W    = 2 * (DIFF_W - 1);
    localparam int SQSUM_W = SQ_W + 2;
    localparam int WIDE_W  = (SQSUM_W > CURV_W) ? SQSUM_W : CURV_W;

    // Counter widths.
    localparam int SEEN_W = $clog2(WIN_LEN + 1);
    localparam int CNT_W  = $clog2(2 * HALF_WINDOW + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic [SQ_W-1:0]              sq_t;
    typedef logic [CURV_W-1:0]            curv_t;
    typedef logic [SEEN_W-1:0]            seen_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    localparam curv_t CURV_MAX      = {CURV_W{1'b1}};
    localparam curv_t THRESH_RESET  = CURV_W'(100000);
    localparam seen_t SEEN_FULL     = SEEN_W'(WIN_LEN);
    localparam cnt_t  CNT_ONE       = CNT_W'(1);
    localparam cnt_t  CNT_MAX       = CNT_W'(2 * HALF_WINDOW);
    localparam cnt_t  LEAD_FIRST    = CNT_W'(HALF_WINDOW + 1);
    localparam cnt_t  LEAD_STEADY   = CNT_W'(1);
    localparam cnt_t  TAIL_FIRST    = CNT_W'(HALF_WINDOW - 1);
    localparam cnt_t  TAIL_STEADY   = CNT_W'(HALF_WINDOW);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SHARP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FLAT  = CFG_IDX_W'(1);

    // Per-point result list description that travels down the pipeline.
    typedef struct packed {
        cnt_t cnt;        // number of results this point releases
        logic zero;       // short cloud: curvature forced to zero
        logic last_cl;    // final result of the list closes the cloud
        logic make_held;  // cloud of exactly the window size: hold one result
    } ctrl_t;

endpackage

`default_nettype wire

[design/point_curvature_window_top.sv]
// Point curvature window: streaming eleven-point curvature with sharp and flat flags.
// Depends on pcw_pkg for widths, constants and the pipeline control struct.
`default_nettype none

// One point is accepted per cycle, while the output is not stalled, as long as
// each point releases at most one result, which is the case for every interior
// point of a cloud. A point that releases a list of results (the point that
// fills the window, which releases six, and the final point of a cloud, which
// releases up to ten) holds in_stall high until its list is out, because the
// single output register delivers one word per cycle while out_stall is low.
// Stages: window update, difference, square, result list, output. Curvature of
// the first and last five points of a cloud repeats that of the nearest interior
// point; clouds of fewer than eleven points give zeros, all delivered with the
// final point. The user must write thresholds through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
module point_curvature_window_top import pcw_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic                     cloud_end,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [CURV_W-1:0]        curvature,
    output logic                     is_sharp,
    output logic                     is_flat,
    output logic                     run_last,
    output logic                     cloud_last,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    // Thresholds.
    curv_t sharp_reg;
    curv_t flat_reg;

    // Window and running window sums.
    coord_t win_reg [3][WIN_LEN];
    sum_t   sum_reg [3];
    sum_t   sum_next [3];
    coord_t in_pt [3];
    seen_t  seen_reg;
    seen_t  seen_next;

    // Pipeline stages.
    logic  p1_valid_reg;
    ctrl_t p1_ctrl_reg;
    ctrl_t front_ctrl;
    logic  p2_valid_reg;
    ctrl_t p2_ctrl_reg;
    diff_t diff_reg [3];
    diff_t diff [3];
    logic  p3_valid_reg;
    ctrl_t p3_ctrl_reg;
    sq_t   sq_reg [3];
    logic signed [2*DIFF_W-1:0] prod [3];

    // Result list and held edge result.
    logic  job_valid_reg;
    logic  job_valid_next;
    logic  job_held_reg;
    logic  job_held_next;
    cnt_t  job_cnt_reg;
    cnt_t  job_cnt_next;
    curv_t job_curv_reg;
    curv_t job_curv_next;
    logic  job_lastcl_reg;
    logic  job_lastcl_next;
    logic  edge_pend_reg;
    logic  edge_pend_next;
    curv_t edge_curv_reg;
    curv_t edge_curv_next;

    // Output register.
    logic  out_valid_reg;
    curv_t out_curv_reg;
    logic  out_sharp_reg;
    logic  out_flat_reg;
    logic  out_rl_reg;
    logic  out_cl_reg;

    logic  accept;
    logic  adv;
    logic  out_free;
    logic  job_last_emit;
    logic  load_job;
    logic  first;
    seen_t ps_inc;
    cnt_t  lead;
    cnt_t  tail;
    logic [SQSUM_W-1:0] sq_sum;
    logic [WIDE_W-1:0]  sq_wide;
    curv_t sat_curv;
    curv_t emit_curv;
    logic  emit_cl;
    logic  emit_rl;

    assign out_free      = !out_valid_reg || !out_stall;
    assign job_last_emit = out_free && job_valid_reg &&
                           (job_held_reg ? (job_cnt_reg == '0) : (job_cnt_reg == CNT_ONE));
    assign adv           = !job_valid_reg || job_last_emit;
    assign in_stall      = !adv;
    assign accept        = in_valid && !in_stall;
    assign load_job      = adv && p3_valid_reg && ((p3_ctrl_reg.cnt != '0) || edge_pend_reg);

    // Front end: new point, running sums and the result list for this point.
    always_comb
    begin
        in_pt[0] = coord_t'(pos_x);
        in_pt[1] = coord_t'(pos_y);
        in_pt[2] = coord_t'(pos_z);
        for (int a = 0; a < 3; a++)
        begin
            sum_next[a] = sum_reg[a] + sum_t'(in_pt[a]) - sum_t'(win_reg[a][0]);
        end

        first  = (seen_reg < SEEN_FULL);
        ps_inc = first ? seen_reg + SEEN_W'(1) : seen_reg;
        lead   = first ? LEAD_FIRST : LEAD_STEADY;
        tail   = first ? TAIL_FIRST : TAIL_STEADY;
        if (ps_inc < SEEN_FULL)
        begin
            front_ctrl.cnt       = cloud_end ? CNT_W'(ps_inc) : '0;
            front_ctrl.zero      = 1'b1;
            front_ctrl.last_cl   = 1'b1;
            front_ctrl.make_held = 1'b0;
        end
        else
        begin
            front_ctrl.cnt       = cloud_end ? lead + tail : lead;
            front_ctrl.zero      = 1'b0;
            front_ctrl.last_cl   = cloud_end && !first;
            front_ctrl.make_held = cloud_end && first;
        end
        seen_next = cloud_end ? '0 : ps_inc;
    end

    // Difference per axis: window sum minus eleven times the center point.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a] = diff_t'(sum_reg[a])
                      - diff_t'(WIN_LEN) * diff_t'(win_reg[a][HALF_WINDOW]);
            prod[a] = diff_reg[a] * diff_reg[a];
        end
    end

    // Sum of squares, saturated to the curvature width.
    always_comb
    begin
        sq_sum  = SQSUM_W'(sq_reg[0]) + SQSUM_W'(sq_reg[1]) + SQSUM_W'(sq_reg[2]);
        sq_wide = WIDE_W'(sq_sum);
        if (sq_wide > WIDE_W'(CURV_MAX))
        begin
            sat_curv = CURV_MAX;
        end
        else
        begin
            sat_curv = sq_wide[CURV_W-1:0];
        end
    end

    // Result list bookkeeping: a held edge result goes out ahead of the list.
    always_comb
    begin
        job_valid_next  = job_valid_reg;
        job_held_next   = job_held_reg;
        job_cnt_next    = job_cnt_reg;
        job_curv_next   = job_curv_reg;
        job_lastcl_next = job_lastcl_reg;
        edge_pend_next  = edge_pend_reg;
        edge_curv_next  = edge_curv_reg;

        if (out_free && job_valid_reg)
        begin
            if (job_held_reg)
            begin
                job_held_next = 1'b0;
            end
            else
            begin
                job_cnt_next = job_cnt_reg - CNT_ONE;
            end
        end

        if (adv)
        begin
            job_valid_next  = load_job;
            job_held_next   = edge_pend_reg;
            job_cnt_next    = p3_ctrl_reg.cnt;
            job_curv_next   = p3_ctrl_reg.zero ? '0 : sat_curv;
            job_lastcl_next = p3_ctrl_reg.last_cl;
        end

        if (load_job)
        begin
            edge_pend_next = p3_ctrl_reg.make_held;
            if (p3_ctrl_reg.make_held)
            begin
                edge_curv_next = sat_curv;
            end
        end

        emit_curv = job_held_reg ? edge_curv_reg : job_curv_reg;
        emit_cl   = job_held_reg ? 1'b1 : (job_lastcl_reg && (job_cnt_reg == CNT_ONE));
        emit_rl   = job_held_reg ? (job_cnt_reg == '0) : (job_cnt_reg == CNT_ONE);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharp_reg     <= THRESH_RESET;
            flat_reg      <= THRESH_RESET;
            seen_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
            job_held_reg  <= 1'b0;
            job_cnt_reg   <= '0;
            edge_pend_reg <= 1'b0;
            edge_curv_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                sum_reg[a] <= '0;
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    win_reg[a][i] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHARP: sharp_reg <= cfg_data;
                    REG_FLAT:  flat_reg  <= cfg_data;
                    default:   ;
                endcase
            end

            if (accept)
            begin
                seen_reg <= seen_next;
                for (int a = 0; a < 3; a++)
                begin
                    sum_reg[a] <= sum_next[a];
                    for (int i = 0; i < WIN_LEN - 1; i++)
                    begin
                        win_reg[a][i] <= win_reg[a][i+1];
                    end
                    win_reg[a][WIN_LEN-1] <= in_pt[a];
                end
            end

            if (adv)
            begin
                p1_valid_reg <= accept;
                p2_valid_reg <= p1_valid_reg;
                p3_valid_reg <= p2_valid_reg;
            end

            job_valid_reg <= job_valid_next;
            job_held_reg  <= job_held_next;
            job_cnt_reg   <= job_cnt_next;
            edge_pend_reg <= edge_pend_next;
            edge_curv_reg <= edge_curv_next;

            if (out_free)
            begin
                out_valid_reg <= job_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ctrl_reg <= front_ctrl;
            p2_ctrl_reg <= p1_ctrl_reg;
            p3_ctrl_reg <= p2_ctrl_reg;
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= diff[a];
                sq_reg[a]   <= prod[a][SQ_W-1:0];
            end
        end

        job_curv_reg   <= job_curv_next;
        job_lastcl_reg <= job_lastcl_next;

        if (out_free && job_valid_reg)
        begin
            out_curv_reg  <= emit_curv;
            out_sharp_reg <= (emit_curv > sharp_reg);
            out_flat_reg  <= (emit_curv < flat_reg);
            out_rl_reg    <= emit_rl;
            out_cl_reg    <= emit_cl;
        end
    end

    assign out_valid  = out_valid_reg;
    assign curvature  = out_curv_reg;
    assign is_sharp   = out_sharp_reg;
    assign is_flat    = out_flat_reg;
    assign run_last   = out_rl_reg;
    assign cloud_last = out_cl_reg;

    // A loaded result list always has something to deliver.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_held_reg || (job_cnt_reg != '0)))
        else $error("empty result list loaded");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_cnt_reg <= CNT_MAX)
        else $error("result list longer than the window allows");

    // A stalled output must not consume entries of a pending result list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && job_valid_reg) |=>
            ($stable(job_cnt_reg) && $stable(job_held_reg)))
        else $error("result list advanced under output stall");

    // A held edge result appears only with the full list of a window-sized cloud.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(edge_pend_reg) |-> (job_valid_reg && !job_held_reg && (job_cnt_reg == CNT_MAX)))
        else $error("edge result held without a window-sized cloud");

    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_FULL)
        else $error("point count beyond window length");

endmodule

`default_nettype wire
